// ===== hdl/scb_pkg.sv =====
// Shared types, codes and constants for the span coalescing table.
package scb_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam logic [1:0] ALIGN_MASK = 2'b11;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_TAKE   = 1'b1;

   localparam logic [1:0] RS_RECORDED = 2'd0;
   localparam logic [1:0] RS_REJECTED = 2'd1;
   localparam logic [1:0] RS_TAKE     = 2'd2;
   localparam logic [1:0] RS_BAD      = 2'd3;

   typedef struct packed {
      logic [1:0]  layer;
      logic        provenance;
      logic [31:0] source_pc;
      logic [31:0] native_value;
   } tag_type;

   typedef struct packed {
      logic [31:0] b_addr;
      logic [31:0] e_addr;
      tag_type     tag;
   } entry_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] span_begin;
      logic [31:0] span_end;
      logic [1:0]  layer;
      logic        provenance;
      logic [31:0] source_pc;
      logic [31:0] native_value;
      logic [31:0] list_address;
      logic [31:0] list_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_begin;
      logic [31:0] out_end;
      logic [1:0]  out_layer;
      logic        out_provenance;
      logic [31:0] out_source_pc;
      logic [31:0] out_native_value;
      logic        span_valid;
      logic        evicted;
      logic [4:0]  merged_count;
      logic [4:0]  partial_count;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC_WALK,
      ST_SHIFT,
      ST_APPEND,
      ST_REC_DONE,
      ST_TAKE_BAD,
      ST_TAKE_WALK,
      ST_SCAN,
      ST_FETCH,
      ST_EMIT,
      ST_FINAL
   } state_type;

endpackage

// ===== hdl/scb_ifs.sv =====
// Valid/ready channel interfaces for requests and responses.
interface scb_req_if;
   logic              valid;
   logic              ready;
   scb_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface scb_rsp_if;
   logic              valid;
   logic              ready;
   scb_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/span_coalescing_table_top.sv =====
// Span coalescing table: age-ordered span store with merge, evict and sorted take.
// The table holds up to TABLE_DEPTH tagged spans, oldest at index 0, in a memory with one
// read and one write port that a sequencer walks one entry per cycle, compacting survivors
// in place. A record transfer folds equal-tag overlapping or touching spans into the new
// one and appends it unless a foreign-tag overlap rejects it; when the table is full and
// nothing merges, a shift pass drops the oldest entry first. A take transfer walks the
// table once, parking contained spans in a holding memory, then emits them in ascending
// begin order by a selection scan: each emitted span takes one scan over the n contained
// spans. The walk and the scan use separate compare paths; the block takes no new request
// until the last response of the current one is loaded into the output register, which
// may still wait there while the next request is taken.
module span_coalescing_table_top #(
   parameter int TABLE_DEPTH = scb_pkg::TABLE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   scb_req_if.sink    req_chan,
   scb_rsp_if.source  rsp_chan
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

   // table and holding memories
   scb_pkg::entry_type tbl_mem [TABLE_DEPTH];
   scb_pkg::entry_type hold_mem [TABLE_DEPTH];
   scb_pkg::entry_type tbl_rd_ff, hold_rd_ff, tbl_wd, hold_wd;
   logic [IW-1:0] tbl_ra, tbl_wa, hold_ra, hold_wa;
   logic          tbl_we, hold_we;

   scb_pkg::state_type state_ff, state_in;
   logic [IW-1:0] r_ff, r_in, j_ff, j_in, best_ff, best_in;
   logic [CW-1:0] w_ff, w_in, occ_ff, occ_in, n_ff, n_in, k_ff, k_in;
   logic [31:0]   cur_b_ff, cur_b_in, cur_e_ff, cur_e_in;
   logic [31:0]   addr_ff, addr_in, lend_ff, lend_in, best_b_ff, best_b_in;
   scb_pkg::tag_type tag_ff, tag_in;
   logic [4:0]    merged_ff, merged_in, partial_ff, partial_in;
   logic          rej_ff, rej_in, ev_ff, ev_in, found_ff, found_in;
   logic [TABLE_DEPTH-1:0] emitted_ff, emitted_in;
   logic          rsp_valid_ff, rsp_valid_in;
   scb_pkg::rsp_type rsp_data_ff, rsp_data_in, rsp_new;

   logic        out_free, load, take_bad, walk_last, scan_last, cand;
   logic        ov, adj, same, isect, contained;
   logic [32:0] sum33;

   assign req_chan.ready = (state_ff == scb_pkg::ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // take range check
   assign sum33 = {1'b0, req_chan.data.list_address} + {1'b0, req_chan.data.list_size};
   assign take_bad = ((req_chan.data.list_address[1:0] & scb_pkg::ALIGN_MASK) != 2'b00) ||
                     ((req_chan.data.list_size[1:0] & scb_pkg::ALIGN_MASK) != 2'b00) ||
                     sum33[32];

   // shared compare path on the entry under the walk
   assign ov  = (cur_b_ff < tbl_rd_ff.e_addr) && (tbl_rd_ff.b_addr < cur_e_ff);
   assign adj = (cur_e_ff == tbl_rd_ff.b_addr) || (tbl_rd_ff.e_addr == cur_b_ff);
   assign same = (tbl_rd_ff.tag == tag_ff);
   assign isect = (tbl_rd_ff.b_addr < lend_ff) && (addr_ff < tbl_rd_ff.e_addr);
   assign contained = (tbl_rd_ff.b_addr >= addr_ff) && (tbl_rd_ff.e_addr <= lend_ff);
   assign walk_last = ((CW'(r_ff) + 1'b1) == occ_ff);
   assign scan_last = ((CW'(j_ff) + 1'b1) == n_ff);
   assign cand = !emitted_ff[j_ff] && (!found_ff || (hold_rd_ff.b_addr < best_b_ff));

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      tbl_rd_ff <= tbl_mem[tbl_ra];
      if (hold_we) begin
         hold_mem[hold_wa] <= hold_wd;
      end
      // write-through: a span parked at index 0 on the last walk cycle is seen by the first scan
      hold_rd_ff <= (hold_we && (hold_wa == hold_ra)) ? hold_wd : hold_mem[hold_ra];
   end

   always_comb begin
      state_in = state_ff;
      r_in = r_ff; j_in = j_ff; best_in = best_ff;
      w_in = w_ff; occ_in = occ_ff; n_in = n_ff; k_in = k_ff;
      cur_b_in = cur_b_ff; cur_e_in = cur_e_ff; tag_in = tag_ff;
      addr_in = addr_ff; lend_in = lend_ff; best_b_in = best_b_ff;
      merged_in = merged_ff; partial_in = partial_ff;
      rej_in = rej_ff; ev_in = ev_ff; found_in = found_ff;
      emitted_in = emitted_ff;
      tbl_ra = '0; tbl_we = 1'b0; tbl_wa = w_ff[IW-1:0]; tbl_wd = tbl_rd_ff;
      hold_ra = '0; hold_we = 1'b0; hold_wa = n_ff[IW-1:0]; hold_wd = tbl_rd_ff;
      load = 1'b0;
      rsp_new = '0;

      unique case (state_ff)
         scb_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               r_in = '0; w_in = '0; n_in = '0; k_in = '0;
               merged_in = '0; partial_in = '0; rej_in = 1'b0; ev_in = 1'b0;
               cur_b_in = req_chan.data.span_begin;
               cur_e_in = req_chan.data.span_end;
               tag_in = {req_chan.data.layer, req_chan.data.provenance,
                         req_chan.data.source_pc, req_chan.data.native_value};
               addr_in = req_chan.data.list_address;
               lend_in = sum33[31:0];
               emitted_in = '0;
               if (req_chan.data.kind == scb_pkg::KIND_RECORD) begin
                  state_in = (occ_ff == '0) ? scb_pkg::ST_APPEND : scb_pkg::ST_REC_WALK;
               end else if (take_bad) begin
                  state_in = scb_pkg::ST_TAKE_BAD;
               end else begin
                  state_in = (occ_ff == '0) ? scb_pkg::ST_FINAL : scb_pkg::ST_TAKE_WALK;
               end
            end
         end
         scb_pkg::ST_REC_WALK: begin
            tbl_ra = r_ff + 1'b1;
            if (!rej_ff && same && (ov || adj)) begin
               if (tbl_rd_ff.b_addr < cur_b_ff) cur_b_in = tbl_rd_ff.b_addr;
               if (tbl_rd_ff.e_addr > cur_e_ff) cur_e_in = tbl_rd_ff.e_addr;
               merged_in = merged_ff + 1'b1;
            end else begin
               if (!rej_ff && ov) rej_in = 1'b1;
               tbl_we = 1'b1;
               w_in = w_ff + 1'b1;
            end
            r_in = r_ff + 1'b1;
            if (walk_last) begin
               if (rej_in) begin
                  occ_in = w_in;
                  state_in = scb_pkg::ST_REC_DONE;
               end else if (w_in == FULL) begin
                  tbl_ra = IW'(1);
                  r_in = IW'(1);
                  state_in = scb_pkg::ST_SHIFT;
               end else begin
                  state_in = scb_pkg::ST_APPEND;
               end
            end
         end
         scb_pkg::ST_SHIFT: begin
            // drop the oldest entry by moving every later one down a slot
            tbl_ra = r_ff + 1'b1;
            tbl_we = 1'b1;
            tbl_wa = r_ff - 1'b1;
            r_in = r_ff + 1'b1;
            if (walk_last) begin
               w_in = FULL - 1'b1;
               ev_in = 1'b1;
               state_in = scb_pkg::ST_APPEND;
            end
         end
         scb_pkg::ST_APPEND: begin
            tbl_we = 1'b1;
            tbl_wd = {cur_b_ff, cur_e_ff, tag_ff};
            occ_in = w_ff + 1'b1;
            state_in = scb_pkg::ST_REC_DONE;
         end
         scb_pkg::ST_REC_DONE: begin
            rsp_new.status = rej_ff ? scb_pkg::RS_REJECTED : scb_pkg::RS_RECORDED;
            rsp_new.evicted = ev_ff;
            rsp_new.merged_count = merged_ff;
            rsp_new.last = 1'b1;
            if (out_free) begin
               load = 1'b1;
               state_in = scb_pkg::ST_IDLE;
            end
         end
         scb_pkg::ST_TAKE_BAD: begin
            rsp_new.status = scb_pkg::RS_BAD;
            rsp_new.last = 1'b1;
            if (out_free) begin
               load = 1'b1;
               state_in = scb_pkg::ST_IDLE;
            end
         end
         scb_pkg::ST_TAKE_WALK: begin
            tbl_ra = r_ff + 1'b1;
            if (!isect) begin
               tbl_we = 1'b1;
               w_in = w_ff + 1'b1;
            end else if (contained) begin
               hold_we = 1'b1;
               n_in = n_ff + 1'b1;
            end else begin
               partial_in = partial_ff + 1'b1;
            end
            r_in = r_ff + 1'b1;
            if (walk_last) begin
               occ_in = w_in;
               j_in = '0;
               found_in = 1'b0;
               state_in = (n_in == '0) ? scb_pkg::ST_FINAL : scb_pkg::ST_SCAN;
            end
         end
         scb_pkg::ST_SCAN: begin
            // strict less-than keeps the oldest of equal begins
            hold_ra = j_ff + 1'b1;
            if (cand) begin
               found_in = 1'b1;
               best_in = j_ff;
               best_b_in = hold_rd_ff.b_addr;
            end
            j_in = j_ff + 1'b1;
            if (scan_last) state_in = scb_pkg::ST_FETCH;
         end
         scb_pkg::ST_FETCH: begin
            hold_ra = best_ff;
            state_in = scb_pkg::ST_EMIT;
         end
         scb_pkg::ST_EMIT: begin
            hold_ra = best_ff;
            rsp_new.status = scb_pkg::RS_TAKE;
            rsp_new.out_begin = hold_rd_ff.b_addr;
            rsp_new.out_end = hold_rd_ff.e_addr;
            rsp_new.out_layer = hold_rd_ff.tag.layer;
            rsp_new.out_provenance = hold_rd_ff.tag.provenance;
            rsp_new.out_source_pc = hold_rd_ff.tag.source_pc;
            rsp_new.out_native_value = hold_rd_ff.tag.native_value;
            rsp_new.span_valid = 1'b1;
            if (out_free) begin
               load = 1'b1;
               hold_ra = '0;
               emitted_in[best_ff] = 1'b1;
               k_in = k_ff + 1'b1;
               j_in = '0;
               found_in = 1'b0;
               state_in = (k_in == n_ff) ? scb_pkg::ST_FINAL : scb_pkg::ST_SCAN;
            end
         end
         scb_pkg::ST_FINAL: begin
            rsp_new.status = scb_pkg::RS_TAKE;
            rsp_new.partial_count = partial_ff;
            rsp_new.last = 1'b1;
            if (out_free) begin
               load = 1'b1;
               state_in = scb_pkg::ST_IDLE;
            end
         end
         default: state_in = scb_pkg::ST_IDLE;
      endcase

      rsp_data_in = load ? rsp_new : rsp_data_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scb_pkg::ST_IDLE;
         occ_ff <= '0;
         rsp_valid_ff <= 1'b0;
         emitted_ff <= '0;
         found_ff <= 1'b0;
         rej_ff <= 1'b0;
         ev_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         emitted_ff <= emitted_in;
         found_ff <= found_in;
         rej_ff <= rej_in;
         ev_ff <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; j_ff <= j_in; best_ff <= best_in;
      w_ff <= w_in; n_ff <= n_in; k_ff <= k_in;
      cur_b_ff <= cur_b_in; cur_e_ff <= cur_e_in; tag_ff <= tag_in;
      addr_ff <= addr_in; lend_ff <= lend_in; best_b_ff <= best_b_in;
      merged_ff <= merged_in; partial_ff <= partial_in;
      rsp_data_ff <= rsp_data_in;
   end

   // occupancy never passes the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL) else $error("occupancy above table size");

   // compaction write never overtakes the walk read
   a_compact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scb_pkg::ST_REC_WALK || state_ff == scb_pkg::ST_TAKE_WALK)
      |-> (w_ff <= CW'(r_ff))) else $error("compaction overtook walk");

   // an accepted transfer always starts work
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != scb_pkg::ST_IDLE))
      else $error("request accepted without work");

   // emitted spans never exceed the contained count
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scb_pkg::ST_EMIT) |-> (k_ff < n_ff))
      else $error("emit count overrun");

endmodule

// ===== test/span_coalescing_table_top_test.sv =====
// Self-checking testbench for the span coalescing table: directed table plus random traffic.
module span_coalescing_table_top_test;

   // Clock and reset. Inputs move on the falling edge, outputs are sampled on the rising edge.
   logic clock;
   logic reset;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   scb_req_if req_chan ();
   scb_rsp_if rsp_chan ();

   span_coalescing_table_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the span table: index 0 is the oldest entry.
   scb_pkg::entry_type shadow_tbl [scb_pkg::TABLE_DEPTH];
   int        shadow_occ;

   // Responses still owed by the block, oldest first.
   scb_pkg::rsp_type pending_rsp [$];

   int mismatch_count;
   int send_idle_pct;
   int rsp_stall_pct;

   // Tags used by well-formed traffic, so that equal-tag merges actually happen.
   scb_pkg::tag_type tag_pool [3];
   logic [31:0] addr_window;

   // Directed stimulus: typed expectation only where it is obvious.
   typedef struct {
      scb_pkg::req_type rq;
      bit      typed;
      scb_pkg::rsp_type want;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic void owe_rsp(scb_pkg::rsp_type r);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   function automatic void add_row(dir_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic void drop_slot(int k);
      for (int j = k; j + 1 < shadow_occ; j++)
         shadow_tbl[j] = shadow_tbl[j + 1];
      shadow_occ--;
   endfunction

   function automatic scb_pkg::rsp_type status_rsp(logic [1:0] st, logic ev, int merged,
                                                    int partial);
      scb_pkg::rsp_type r;
      r = '0;
      r.status        = st;
      r.evicted       = ev;
      r.merged_count  = merged[4:0];
      r.partial_count = partial[4:0];
      r.last          = 1'b1;
      return r;
   endfunction

   // Record: walk oldest first, fold equal-tag overlapping or touching spans into the
   // incoming one, reject on a foreign-tag overlap, evict the oldest when full.
   function automatic void record_span(scb_pkg::req_type rq);
      logic [31:0] b;
      logic [31:0] e;
      scb_pkg::tag_type tg;
      int          i;
      int          merged;
      logic        ev;
      logic        ov;
      logic        adj;
      b = rq.span_begin;
      e = rq.span_end;
      tg.layer        = rq.layer;
      tg.provenance   = rq.provenance;
      tg.source_pc    = rq.source_pc;
      tg.native_value = rq.native_value;
      i = 0;
      merged = 0;
      ev = 1'b0;
      while (i < shadow_occ) begin
         ov  = (b < shadow_tbl[i].e_addr) && (shadow_tbl[i].b_addr < e);
         adj = (e == shadow_tbl[i].b_addr) || (shadow_tbl[i].e_addr == b);
         if (shadow_tbl[i].tag == tg && (ov || adj)) begin
            if (shadow_tbl[i].b_addr < b) b = shadow_tbl[i].b_addr;
            if (shadow_tbl[i].e_addr > e) e = shadow_tbl[i].e_addr;
            drop_slot(i);
            merged++;
         end else if (ov) begin
            // merges already done stay removed
            owe_rsp(status_rsp(scb_pkg::RS_REJECTED, 1'b0, merged, 0));
            return;
         end else begin
            i++;
         end
      end
      if (shadow_occ >= scb_pkg::TABLE_DEPTH) begin
         drop_slot(0);
         ev = 1'b1;
      end
      shadow_tbl[shadow_occ].b_addr = b;
      shadow_tbl[shadow_occ].e_addr = e;
      shadow_tbl[shadow_occ].tag    = tg;
      shadow_occ++;
      owe_rsp(status_rsp(scb_pkg::RS_RECORDED, ev, merged, 0));
   endfunction

   // Take: drop every intersecting entry, emit contained ones sorted by begin (stable).
   function automatic void take_spans(scb_pkg::req_type rq);
      logic [32:0] end_wide;
      logic [31:0] lend;
      scb_pkg::entry_type held [$];
      scb_pkg::rsp_type   r;
      int          i;
      int          j;
      int          partial;
      end_wide = {1'b0, rq.list_address} + {1'b0, rq.list_size};
      if ((rq.list_address[1:0] & scb_pkg::ALIGN_MASK) != 2'b00 ||
          (rq.list_size[1:0] & scb_pkg::ALIGN_MASK) != 2'b00 ||
          end_wide > 33'hFFFF_FFFF) begin
         owe_rsp(status_rsp(scb_pkg::RS_BAD, 1'b0, 0, 0));
         return;
      end
      lend = end_wide[31:0];
      i = 0;
      partial = 0;
      while (i < shadow_occ) begin
         if (!(shadow_tbl[i].b_addr < lend && rq.list_address < shadow_tbl[i].e_addr)) begin
            i++;
         end else begin
            if (shadow_tbl[i].b_addr >= rq.list_address && shadow_tbl[i].e_addr <= lend) begin
               j = held.size();
               while (j > 0 && held[j - 1].b_addr > shadow_tbl[i].b_addr)
                  j--;
               held.insert(j, shadow_tbl[i]);
            end else begin
               partial++;
            end
            drop_slot(i);
         end
      end
      foreach (held[k]) begin
         r = '0;
         r.status           = scb_pkg::RS_TAKE;
         r.out_begin        = held[k].b_addr;
         r.out_end          = held[k].e_addr;
         r.out_layer        = held[k].tag.layer;
         r.out_provenance   = held[k].tag.provenance;
         r.out_source_pc    = held[k].tag.source_pc;
         r.out_native_value = held[k].tag.native_value;
         r.span_valid       = 1'b1;
         owe_rsp(r);
      end
      owe_rsp(status_rsp(scb_pkg::RS_TAKE, 1'b0, 0, partial));
   endfunction

   function automatic void predict_table_step(scb_pkg::req_type rq);
      if (rq.kind == scb_pkg::KIND_RECORD)
         record_span(rq);
      else
         take_spans(rq);
   endfunction

   function automatic scb_pkg::req_type rec_req(logic [31:0] b, logic [31:0] e,
                                                 scb_pkg::tag_type tg);
      scb_pkg::req_type r;
      r = '0;
      r.kind         = scb_pkg::KIND_RECORD;
      r.span_begin   = b;
      r.span_end     = e;
      r.layer        = tg.layer;
      r.provenance   = tg.provenance;
      r.source_pc    = tg.source_pc;
      r.native_value = tg.native_value;
      return r;
   endfunction

   function automatic scb_pkg::req_type take_req(logic [31:0] a, logic [31:0] s);
      scb_pkg::req_type r;
      r = '0;
      r.kind         = scb_pkg::KIND_TAKE;
      r.list_address = a;
      r.list_size    = s;
      return r;
   endfunction

   function automatic scb_pkg::tag_type rand_tag();
      scb_pkg::tag_type t;
      t.layer        = 2'($urandom_range(0, 3));
      t.provenance   = 1'($urandom_range(0, 1));
      t.source_pc    = $urandom;
      t.native_value = $urandom;
      return t;
   endfunction

   // Mostly well-formed traffic in a small window around addr_window; some pure noise.
   function automatic scb_pkg::req_type rand_req();
      scb_pkg::req_type r;
      scb_pkg::tag_type tg;
      logic [31:0] b;
      r.kind         = 1'($urandom_range(0, 1));
      r.span_begin   = $urandom;
      r.span_end     = $urandom;
      r.layer        = 2'($urandom_range(0, 3));
      r.provenance   = 1'($urandom_range(0, 1));
      r.source_pc    = $urandom;
      r.native_value = $urandom;
      r.list_address = $urandom;
      r.list_size    = $urandom;
      if ($urandom_range(0, 99) < 8)
         return r;
      if ($urandom_range(0, 99) < 70) begin
         tg = ($urandom_range(0, 99) < 85) ? tag_pool[$urandom_range(0, 2)] : rand_tag();
         b = addr_window + 32'($urandom_range(0, 63)) * 4;
         r.kind         = scb_pkg::KIND_RECORD;
         r.span_begin   = b;
         r.span_end     = b + 32'($urandom_range(0, 12)) * 4 + 32'($urandom_range(0, 99) < 10);
         r.layer        = tg.layer;
         r.provenance   = tg.provenance;
         r.source_pc    = tg.source_pc;
         r.native_value = tg.native_value;
      end else begin
         r.kind         = scb_pkg::KIND_TAKE;
         r.list_address = addr_window + 32'($urandom_range(0, 63)) * 4;
         r.list_size    = 32'($urandom_range(0, 40)) * 4;
         if ($urandom_range(0, 99) < 10)
            r.list_address[1:0] = 2'($urandom_range(1, 3));
         if ($urandom_range(0, 99) < 5)
            r.list_size[1:0] = 2'($urandom_range(1, 3));
      end
      return r;
   endfunction

   // Drive one transfer; valid stays high into the next item unless the sender idles.
   task automatic send_item(scb_pkg::req_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= rq;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_table_step(rq);
      @(negedge clock);
   endtask

   // Sender holds off until the block has delivered everything it owes.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Receiver: random stalls on the falling edge.
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   // Response checker.
   always @(posedge clock) begin
      scb_pkg::rsp_type want;
      scb_pkg::rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: %p", got);
         end else begin
            want = pending_rsp[0];
            pending_rsp.delete(0);
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response mismatch:");
                  $display("  expected %p", want);
                  $display("  actual   %p", got);
               end
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(12 * 800000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      scb_pkg::tag_type ta;
      scb_pkg::tag_type tb;
      scb_pkg::tag_type tc;
      scb_pkg::tag_type ones;
      dir_row_type row;
      scb_pkg::rsp_type got_want;
      ta = '{layer: 2'd0, provenance: 1'b0, source_pc: 32'h0000_1000, native_value: 32'h0};
      tb = '{layer: 2'd1, provenance: 1'b1, source_pc: 32'h0000_2000, native_value: 32'h5};
      tc = '{layer: 2'd2, provenance: 1'b0, source_pc: 32'h0, native_value: 32'hFFFF_FFFF};
      ones = '1;
      mismatch_count = 0;
      shadow_occ = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows: range checks, merge, reject, empty span, top of address space,
      // sorted take, then a fill past capacity to force eviction.
      row.typed = 1'b1;
      row.rq = take_req(32'h0, 32'h0);
      row.want = status_rsp(scb_pkg::RS_TAKE, 1'b0, 0, 0);         add_row(row);
      row.rq = take_req(32'h1, 32'h4);
      row.want = status_rsp(scb_pkg::RS_BAD, 1'b0, 0, 0);          add_row(row);
      row.rq = take_req(32'h8, 32'h2);
      row.want = status_rsp(scb_pkg::RS_BAD, 1'b0, 0, 0);          add_row(row);
      row.rq = take_req(32'hFFFF_FFFC, 32'h4);                      // passes the 32-bit limit
      row.want = status_rsp(scb_pkg::RS_BAD, 1'b0, 0, 0);          add_row(row);
      row.rq = take_req(32'hFFFF_FFF8, 32'h4);
      row.want = status_rsp(scb_pkg::RS_TAKE, 1'b0, 0, 0);         add_row(row);
      row.rq = rec_req(32'h100, 32'h200, ta);
      row.want = status_rsp(scb_pkg::RS_RECORDED, 1'b0, 0, 0);     add_row(row);
      row.typed = 1'b0;
      row.rq = rec_req(32'h200, 32'h280, ta);   add_row(row);   // touching merge
      row.rq = rec_req(32'h180, 32'h190, tb);   add_row(row);   // foreign overlap
      row.rq = rec_req(32'h300, 32'h300, tb);   add_row(row);   // empty span
      row.rq = rec_req(32'h0, 32'hFFFF_FFFF, tc); add_row(row);
      row.rq = rec_req(32'hFFFF_FFF0, 32'hFFFF_FFFF, ones); add_row(row);
      row.rq = take_req(32'h100, 32'h200);      add_row(row);
      for (int k = 0; k < 15; k++) begin
         row.rq = rec_req(32'h1000 + 32'(k) * 32'h40, 32'h1010 + 32'(k) * 32'h40,
                          (k % 2) ? tb : tc);
         add_row(row);
      end
      row.rq = take_req(32'h0, 32'hFFFF_FFFC);  add_row(row);

      foreach (dir_rows[k]) begin
         send_item(dir_rows[k].rq);
         if (dir_rows[k].typed) begin
            // replace the computed single response with the typed-in one
            got_want = pending_rsp[pending_rsp.size() - 1];
            pending_rsp[pending_rsp.size() - 1] = dir_rows[k].want;
            if (got_want !== dir_rows[k].want)
               $display("note: table row %0d disagrees with shadow prediction", k);
         end
      end
      drain_results();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 74; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 74; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         foreach (tag_pool[k]) tag_pool[k] = rand_tag();
         case ($urandom_range(0, 2))
            0: addr_window = 32'h0;
            1: addr_window = $urandom & 32'hFFFF_FFFC;
            default: addr_window = 32'hFFFF_FE00;
         endcase
         for (int k = 0; k < 44; k++)
            send_item(rand_req());
         drain_results();
      end

      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
